// ===== hw/rtl/btmx_pkg.sv =====
// ----------------------------------------------------------------------------
// btmx_pkg
// Shared types and constants for the binary trie maximum-xor block.
// ----------------------------------------------------------------------------
package btmx_pkg;

   localparam int KEY_BITS   = 31;
   localparam int NODE_COUNT = 65536;
   localparam int LINK_W     = $clog2(NODE_COUNT);
   localparam int LEVEL_W    = $clog2(KEY_BITS);

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_QUERY  = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_WALK = 2'd1,
      S_LEAF = 2'd2,
      S_DONE = 2'd3
   } state_type;

   // both child links of one node
   typedef struct packed {
      logic [LINK_W-1:0] one_child;
      logic [LINK_W-1:0] zero_child;
   } link_word_type;

   // what one trie level decides
   typedef struct packed {
      logic [LINK_W-1:0] next_node;
      logic              take_other;
      logic              alloc;
      link_word_type     wr_word;
   } step_type;

endpackage

// ===== hw/rtl/binary_trie_max_xor.sv =====
// Sequence: a query or an insert that adds no leaf walks S_WALK once per trie level, then
//   S_DONE; an insert that adds a leaf passes S_LEAF between them; clear, unused
//   operations, a refused insert and an empty query go straight to S_DONE.
// Throughput: one item at a time, one link memory read per trie level; the next item is
//   accepted back in S_IDLE after the result loads; S_DONE stalls until the result slot is free.
// Reset: clears sequencer, node counter, root links and result valid; memory not swept.
// ----------------------------------------------------------------------------
// binary_trie_max_xor
// Binary trie over 31-bit keys with insert, maximum-xor query and clear.
// ----------------------------------------------------------------------------
module binary_trie_max_xor
   import btmx_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_operation,
   input  logic [KEY_BITS-1:0]   req_key_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_status,
   output logic [KEY_BITS-1:0]   rsp_best_xor
);

   localparam logic [LEVEL_W-1:0] TOP_LEVEL = LEVEL_W'(KEY_BITS - 1);

   state_type           state_ff, state_in;
   op_type              op_ff, op_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [LEVEL_W-1:0]  level_ff, level_in;
   logic [LINK_W-1:0]   node_ff, node_in;
   logic                chain_ff, chain_in;
   logic [LINK_W-1:0]   last_node_ff, last_node_in;
   link_word_type       root_ff, root_in;
   logic [KEY_BITS-1:0] best_ff, best_in;
   status_type          status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [KEY_BITS-1:0] rsp_best_ff, rsp_best_in;

   logic                mem_we;
   logic [LINK_W-1:0]   mem_wr_addr;
   link_word_type       mem_wr_data;
   link_word_type       mem_rd_data;
   link_word_type       cur_word;
   step_type            step;
   logic                at_top;
   logic                req_fire;
   logic [LINK_W-1:0]   free_nodes;

   assign at_top     = (level_ff == TOP_LEVEL);
   assign cur_word   = at_top ? root_ff : mem_rd_data;
   assign req_fire   = req_valid && req_ready;
   assign free_nodes = LINK_W'(NODE_COUNT - 1) - last_node_ff;

   btmx_level_unit u_level (
      .word      (cur_word),
      .key_bit   (key_ff[level_ff]),
      .is_query  (op_ff == OP_QUERY),
      .chain     (chain_ff),
      .last_node (last_node_ff),
      .step      (step)
   );

   btmx_link_mem u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (step.next_node),
      .rd_data (mem_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         last_node_ff <= '0;
         root_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_node_ff <= last_node_in;
         root_ff      <= root_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      level_ff      <= level_in;
      node_ff       <= node_in;
      chain_ff      <= chain_in;
      best_ff       <= best_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_best_ff   <= rsp_best_in;
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      level_in      = level_ff;
      node_in       = node_ff;
      chain_in      = chain_ff;
      last_node_in  = last_node_ff;
      root_in       = root_ff;
      best_in       = best_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_best_in   = rsp_best_ff;
      mem_we        = 1'b0;
      mem_wr_addr   = node_ff;
      mem_wr_data   = step.wr_word;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in     = op_type'(req_operation);
               key_in    = req_key_value;
               level_in  = TOP_LEVEL;
               node_in   = '0;
               chain_in  = 1'b0;
               best_in   = '0;
               status_in = ST_OK;
               state_in  = S_DONE;
               case (req_operation)
                  OP_INSERT: begin
                     if (free_nodes < LINK_W'(KEY_BITS)) begin
                        status_in = ST_FULL;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
                  OP_QUERY: begin
                     if (last_node_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
                  OP_CLEAR: begin
                     last_node_in = '0;
                     root_in      = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_WALK: begin
            node_in = step.next_node;
            if (op_ff == OP_QUERY) begin
               if (step.take_other) begin
                  best_in = best_ff | (KEY_BITS'(1) << level_ff);
               end
            end else if (step.alloc) begin
               last_node_in = step.next_node;
               chain_in     = 1'b1;
               if (at_top) begin
                  root_in = step.wr_word;
               end else begin
                  mem_we = 1'b1;
               end
            end
            if (level_ff == '0) begin
               // a new leaf still needs its links zeroed
               if (op_ff == OP_INSERT && (chain_ff || step.alloc)) begin
                  state_in = S_LEAF;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               level_in = level_ff - LEVEL_W'(1);
            end
         end
         S_LEAF: begin
            mem_we      = 1'b1;
            mem_wr_data = '0;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_best_in   = best_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_ready    = (state_ff == S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_best_xor = rsp_best_ff;

`ifndef ASSERT_OFF
   a_last_node_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |=> (last_node_ff == $past(last_node_ff) ||
                                last_node_ff == $past(last_node_ff) + LINK_W'(1)))
      else $error("node counter moved by more than one in a cycle");

   a_query_not_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && op_ff == OP_QUERY) |-> (status_ff != ST_FULL))
      else $error("query finished with table full status");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_EMPTY) |-> (rsp_best_ff == '0))
      else $error("empty query result carries a nonzero xor");

   a_write_window: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_WALK || state_ff == S_LEAF))
      else $error("link memory written outside the walk");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (last_node_ff == '0 && root_ff == '0))
      else $error("trie not empty after reset");
`endif

endmodule

// ===== hw/rtl/btmx_link_mem.sv =====
// ----------------------------------------------------------------------------
// btmx_link_mem
// Node link memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module btmx_link_mem
   import btmx_pkg::*;
(
   input  logic                clock,
   input  logic                wr_en,
   input  logic [LINK_W-1:0]   wr_addr,
   input  link_word_type       wr_data,
   input  logic [LINK_W-1:0]   rd_addr,
   output link_word_type       rd_data
);

   link_word_type link_mem_ff [NODE_COUNT];
   link_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= link_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/btmx_level_unit.sv =====
// ----------------------------------------------------------------------------
// btmx_level_unit
// One trie level: picks the branch, allocates a node and forms the new links.
// ----------------------------------------------------------------------------
module btmx_level_unit
   import btmx_pkg::*;
(
   input  link_word_type       word,
   input  logic                key_bit,
   input  logic                is_query,
   input  logic                chain,
   input  logic [LINK_W-1:0]   last_node,
   output step_type            step
);

   logic [LINK_W-1:0] same_link;
   logic [LINK_W-1:0] other_link;
   logic [LINK_W-1:0] new_node;

   always_comb begin
      same_link  = key_bit ? word.one_child : word.zero_child;
      other_link = key_bit ? word.zero_child : word.one_child;
      new_node   = last_node + LINK_W'(1);
      step       = '0;
      if (is_query) begin
         step.take_other = (other_link != '0);
         step.next_node  = step.take_other ? other_link : same_link;
      end else if (chain) begin
         // freshly allocated node: only the path link, the other stays absent
         step.alloc     = 1'b1;
         step.next_node = new_node;
         if (key_bit) begin
            step.wr_word.one_child = new_node;
         end else begin
            step.wr_word.zero_child = new_node;
         end
      end else begin
         step.alloc     = (same_link == '0);
         step.next_node = step.alloc ? new_node : same_link;
         step.wr_word   = word;
         if (key_bit) begin
            step.wr_word.one_child = new_node;
         end else begin
            step.wr_word.zero_child = new_node;
         end
      end
   end

endmodule
